@@ rtl/sbls_pkg.sv @@
// Shared constants and codes for the branch literal selector.
package sbls_pkg;

   localparam int MAX_VARIABLES_DEF  = 1024;
   localparam int MAX_CLAUSE_LEN_DEF = 32;
   localparam int SCORE_INT_BITS_DEF = 12;

   localparam int VAR_W = 10;
   localparam int VAL_W = 2;
   localparam int LIT_W = VAR_W + 1;

   localparam logic [VAL_W-1:0] VAL_UNDECIDED = 2'd0;
   localparam logic [VAL_W-1:0] VAL_TRUE      = 2'd1;
   localparam logic [VAL_W-1:0] VAL_FALSE     = 2'd2;

   localparam logic MODE_UNIT  = 1'b0;
   localparam logic MODE_SPLIT = 1'b1;

endpackage

@@ rtl/sbls_ifs.sv @@
// Literal request and selection response channel interfaces.
interface sbls_req_if
   import sbls_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [VAR_W-1:0] variable_index;
   logic             is_positive;
   logic             is_unassigned;
   logic             clause_end;
   logic             formula_end;

   modport source (output valid, variable_index, is_positive, is_unassigned, clause_end,
                   formula_end, input ready);
   modport sink (input valid, variable_index, is_positive, is_unassigned, clause_end,
                 formula_end, output ready);
endinterface

interface sbls_rsp_if
   import sbls_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [VAR_W-1:0] chosen_variable;
   logic [VAL_W-1:0] first_value;
   logic [VAL_W-1:0] second_value;
   logic             conflict;

   modport source (output valid, chosen_variable, first_value, second_value, conflict,
                   input ready);
   modport sink (input valid, chosen_variable, first_value, second_value, conflict,
                 output ready);
endinterface

@@ rtl/sbls_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sbls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/sbls_sat_add.sv @@
// Shared saturating score adder.
module sbls_sat_add #(
   parameter int W = 44
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   output logic [W-1:0] sum
);
   logic [W:0] full;

   assign full = {1'b0, a} + {1'b0, b};
   assign sum  = full[W] ? {W{1'b1}} : full[W-1:0];
endmodule

@@ rtl/sat_branch_literal_selector.sv @@
// Top level: literal stream intake, scoring sequencer and result register.
// Intake is held off until idle. A plain literal is only stored; a unit clause end does
// one score read, add and write-back; a split clause with k unassigned literals fetches
// each literal and does one pass of the shared adder and score read-modify-write per
// literal. Formula end reads the best score, waits for the result to be taken, then a score clear pass.
// Reset: synchronous; starts with a clear pass over all MAX_VARIABLES score entries, mode unit.
module sat_branch_literal_selector
   import sbls_pkg::*;
#(
   parameter int MAX_VARIABLES  = MAX_VARIABLES_DEF,
   parameter int MAX_CLAUSE_LEN = MAX_CLAUSE_LEN_DEF,
   parameter int SCORE_INT_BITS = SCORE_INT_BITS_DEF
) (
   input  logic  clock,
   input  logic  reset,
   input  logic  csr_write_enable,
   input  logic  csr_write_data,
   sbls_req_if.sink   req,
   sbls_rsp_if.source rsp
);
   localparam int SW    = (SCORE_INT_BITS + MAX_CLAUSE_LEN > 64) ? 64 :
                          SCORE_INT_BITS + MAX_CLAUSE_LEN;
   localparam int SA_W  = $clog2(MAX_VARIABLES);
   localparam int CL_AW = $clog2(MAX_CLAUSE_LEN);
   localparam int CNT_W = $clog2(MAX_CLAUSE_LEN + 2);

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b0000000001,
      ST_FETCH    = 10'b0000000010,
      ST_LATCH    = 10'b0000000100,
      ST_READ     = 10'b0000001000,
      ST_ADD      = 10'b0000010000,
      ST_UPD      = 10'b0000100000,
      ST_FINAL_RD = 10'b0001000000,
      ST_FINAL    = 10'b0010000000,
      ST_RESULT   = 10'b0100000000,
      ST_CLEAR    = 10'b1000000000
   } state_type;

   state_type        state_ff, state_in;
   logic             mode_ff, mode_in;
   logic             fmode_ff, fmode_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LIT_W-1:0] sole_ff, sole_in;
   logic [LIT_W-1:0] lit_ff, lit_in;
   logic [VAR_W-1:0] best_var_ff, best_var_in;
   logic [SW-1:0]    best_score_ff, best_score_in;
   logic             conflict_ff, conflict_in;
   logic [SW-1:0]    weight_ff, weight_in;
   logic             check_ff, check_in;
   logic             fe_ff, fe_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] nrep_ff, nrep_in;
   logic [SW-1:0]    t_ff, t_in, f_ff, f_in;
   logic             opp_nz_ff, opp_nz_in;
   logic [SA_W-1:0]  clr_ff, clr_in;
   logic [VAR_W-1:0] rsp_var_ff, rsp_var_in;
   logic [VAL_W-1:0] rsp_first_ff, rsp_first_in;
   logic [VAL_W-1:0] rsp_second_ff, rsp_second_in;
   logic             rsp_conf_ff, rsp_conf_in;

   logic             cl_wr_en;
   logic [LIT_W-1:0] cl_rd_data;
   logic             sc_wr_en;
   logic [SA_W-1:0]  sc_wr_addr, sc_rd_addr;
   logic [2*SW-1:0]  sc_wr_data, sc_rd_data;
   logic [SW-1:0]    add_a, add_b, add_sum;
   logic [SW-1:0]    rd_t, rd_f;
   logic             take, var_ok;
   logic [CNT_W-1:0] cnt_new;
   logic [LIT_W-1:0] req_lit;

   sbls_ram #(.WIDTH(LIT_W), .DEPTH(MAX_CLAUSE_LEN)) u_clause_ram (
      .clock   (clock),
      .wr_en   (cl_wr_en),
      .wr_addr (cnt_ff[CL_AW-1:0]),
      .wr_data (req_lit),
      .rd_addr (idx_ff[CL_AW-1:0]),
      .rd_data (cl_rd_data)
   );

   sbls_ram #(.WIDTH(2*SW), .DEPTH(MAX_VARIABLES)) u_score_ram (
      .clock   (clock),
      .wr_en   (sc_wr_en),
      .wr_addr (sc_wr_addr),
      .wr_data (sc_wr_data),
      .rd_addr (sc_rd_addr),
      .rd_data (sc_rd_data)
   );

   sbls_sat_add #(.W(SW)) u_add (
      .a   (add_a),
      .b   (add_b),
      .sum (add_sum)
   );

   assign rd_t    = sc_rd_data[2*SW-1:SW];
   assign rd_f    = sc_rd_data[SW-1:0];
   assign req_lit = {req.is_positive, req.variable_index};
   assign var_ok  = (req.variable_index != '0) && (32'(req.variable_index) < MAX_VARIABLES);
   assign take    = !conflict_ff && req.is_unassigned && var_ok;
   assign cnt_new = (take && cnt_ff <= CNT_W'(MAX_CLAUSE_LEN)) ? cnt_ff + 1'b1 : cnt_ff;
   assign cl_wr_en = (state_ff == ST_IDLE) && req.valid && take &&
                     (cnt_ff < CNT_W'(MAX_CLAUSE_LEN));

   assign req.ready           = (state_ff == ST_IDLE);
   assign rsp.valid           = (state_ff == ST_RESULT);
   assign rsp.chosen_variable = rsp_var_ff;
   assign rsp.first_value     = rsp_first_ff;
   assign rsp.second_value    = rsp_second_ff;
   assign rsp.conflict        = rsp_conf_ff;

   assign mode_in = csr_write_enable ? csr_write_data : mode_ff;

   always_comb begin
      state_in      = state_ff;
      fmode_in      = fmode_ff;
      cnt_in        = cnt_ff;
      sole_in       = sole_ff;
      lit_in        = lit_ff;
      best_var_in   = best_var_ff;
      best_score_in = best_score_ff;
      conflict_in   = conflict_ff;
      weight_in     = weight_ff;
      check_in      = check_ff;
      fe_in         = fe_ff;
      idx_in        = idx_ff;
      nrep_in       = nrep_ff;
      t_in          = t_ff;
      f_in          = f_ff;
      opp_nz_in     = opp_nz_ff;
      clr_in        = clr_ff;
      rsp_var_in    = rsp_var_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_conf_in   = rsp_conf_ff;
      sc_wr_en      = 1'b0;
      sc_wr_addr    = SA_W'(lit_ff[VAR_W-1:0]);
      sc_wr_data    = {t_ff, f_ff};
      sc_rd_addr    = SA_W'(lit_ff[VAR_W-1:0]);
      add_a         = t_ff;
      add_b         = f_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               if (take) begin
                  sole_in = req_lit;
               end
               cnt_in   = cnt_new;
               fe_in    = req.formula_end;
               fmode_in = mode_ff;
               if (req.clause_end || req.formula_end) begin
                  cnt_in = '0;
                  idx_in = '0;
                  if (!conflict_ff && mode_ff == MODE_UNIT && cnt_new == CNT_W'(1)) begin
                     lit_in    = take ? req_lit : sole_ff;
                     weight_in = {{(SW-1){1'b0}}, 1'b1} << (MAX_CLAUSE_LEN - 1);
                     check_in  = 1'b1;
                     state_in  = ST_READ;
                  end else if (!conflict_ff && mode_ff == MODE_SPLIT && cnt_new != '0 &&
                               cnt_new <= CNT_W'(MAX_CLAUSE_LEN)) begin
                     nrep_in   = cnt_new;
                     weight_in = {{(SW-1){1'b0}}, 1'b1} <<
                                 (CNT_W'(MAX_CLAUSE_LEN) - cnt_new);
                     check_in  = 1'b0;
                     state_in  = ST_FETCH;
                  end else if (req.formula_end) begin
                     state_in = ST_FINAL_RD;
                  end
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            lit_in   = cl_rd_data;
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            add_a = lit_ff[VAR_W] ? rd_t : rd_f;
            add_b = weight_ff;
            if (lit_ff[VAR_W]) begin
               t_in      = add_sum;
               f_in      = rd_f;
               opp_nz_in = (rd_f != '0);
            end else begin
               t_in      = rd_t;
               f_in      = add_sum;
               opp_nz_in = (rd_t != '0);
            end
            state_in = ST_UPD;
         end
         ST_UPD: begin
            sc_wr_en = 1'b1;
            if (check_ff && opp_nz_ff) begin
               conflict_in = 1'b1;
            end else if (add_sum > best_score_ff) begin
               best_score_in = add_sum;
               best_var_in   = lit_ff[VAR_W-1:0];
            end
            if (check_ff || idx_ff == nrep_ff - 1'b1) begin
               state_in = fe_ff ? ST_FINAL_RD : ST_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FINAL_RD: begin
            sc_rd_addr = SA_W'(best_var_ff);
            state_in   = ST_FINAL;
         end
         ST_FINAL: begin
            rsp_var_in    = best_var_ff;
            rsp_first_in  = VAL_UNDECIDED;
            rsp_second_in = VAL_UNDECIDED;
            rsp_conf_in   = conflict_ff;
            if (!conflict_ff && best_var_ff != '0) begin
               rsp_first_in = (rd_t > rd_f) ? VAL_TRUE : VAL_FALSE;
               if (fmode_ff == MODE_SPLIT) begin
                  rsp_second_in = (rd_t > rd_f) ? VAL_FALSE : VAL_TRUE;
               end
            end
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp.ready) begin
               clr_in        = '0;
               sole_in       = '0;
               best_var_in   = '0;
               best_score_in = '0;
               conflict_in   = 1'b0;
               state_in      = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            sc_wr_en   = 1'b1;
            sc_wr_addr = clr_ff;
            sc_wr_data = '0;
            if (32'(clr_ff) == MAX_VARIABLES - 1) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         mode_ff       <= MODE_UNIT;
         cnt_ff        <= '0;
         sole_ff       <= '0;
         best_var_ff   <= '0;
         best_score_ff <= '0;
         conflict_ff   <= 1'b0;
         clr_ff        <= '0;
         fe_ff         <= 1'b0;
         idx_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         cnt_ff        <= cnt_in;
         sole_ff       <= sole_in;
         best_var_ff   <= best_var_in;
         best_score_ff <= best_score_in;
         conflict_ff   <= conflict_in;
         clr_ff        <= clr_in;
         fe_ff         <= fe_in;
         idx_ff        <= idx_in;
      end
      fmode_ff      <= fmode_in;
      lit_ff        <= lit_in;
      weight_ff     <= weight_in;
      check_ff      <= check_in;
      nrep_ff       <= nrep_in;
      t_ff          <= t_in;
      f_ff          <= f_in;
      opp_nz_ff     <= opp_nz_in;
      rsp_var_ff    <= rsp_var_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_conf_ff   <= rsp_conf_in;
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid))
      else $error("intake open while result pending");

   a_conflict_undecided: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.conflict |-> rsp.first_value == VAL_UNDECIDED &&
                                    rsp.second_value == VAL_UNDECIDED)
      else $error("conflict result carries a value");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready |=> !req.ready && !rsp.valid)
      else $error("no clear pass after result");

   a_none_found: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.chosen_variable == '0 |-> rsp.first_value == VAL_UNDECIDED)
      else $error("value given without a variable");
endmodule
